### design/admission_table_with_waitlist_top_assert.svh
// Assertion macros shared by the admission table RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef ADMISSION_TABLE_WITH_WAITLIST_TOP_ASSERT_SVH
`define ADMISSION_TABLE_WITH_WAITLIST_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ADM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("admission table assertion failed");

// Next-cycle implication, checked outside reset.
`define ADM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("admission table assertion failed");

`endif

### design/adm_pkg.sv
// Shared types and constants for the admission table with waitlist.
// Used by the controller, the datapath and the top level; no dependencies.
package adm_pkg;

    localparam int ID_W   = 30;
    localparam int CNT_W  = 5;
    localparam int CFG_W  = 5;
    localparam int DATA_W = 32;

    // Register indexes; each register sits at byte address four times its index.
    localparam logic REG_SEAT_LIMIT = 1'b0;
    localparam logic REG_WAIT_LIMIT = 1'b1;

    // Action codes of an input beat.
    localparam logic [1:0] ACT_ADMIT = 2'd0;
    localparam logic [1:0] ACT_JOIN  = 2'd1;
    localparam logic [1:0] ACT_LEAVE = 2'd2;

    // Status codes of a result beat.
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_DUP     = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic [1:0]      action;
        logic [ID_W-1:0] member_id;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]       status;
        logic             promoted_valid;
        logic [ID_W-1:0]  promoted_id;
        logic [CNT_W-1:0] seated_count;
        logic [CNT_W-1:0] waiting_count;
    } t_out_beat;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       take_item;
        logic       scan_start;
        logic       scan_wait;
        logic       scan_run;
        logic       append_seat;
        logic       append_wait;
        logic       move_last;
        logic       promote;
        logic       load_out;
        logic [1:0] status;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic seat_full;
        logic wait_full;
        logic scan_done;
        logic scan_hit;
        logic wait_nonempty;
        logic out_busy;
    } t_dp_stat;

endpackage

### design/adm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; instantiated for the seat table and the waitlist ring.
module adm_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/adm_ctrl.sv
// Controller state machine of the admission table: sequences decode, scan,
// move, promotion and result delivery. Depends on adm_pkg.
module adm_ctrl
    import adm_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic [1:0] i_action,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_ctl_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECODE = 7'b0000010,
        S_SCAN   = 7'b0000100,
        S_RDLAST = 7'b0001000,
        S_MOVE   = 7'b0010000,
        S_PROMO  = 7'b0100000,
        S_FINISH = 7'b1000000
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_action, n_action;
    logic [1:0] r_status, n_status;

    // Next-state and command decode.
    always_comb begin
        n_state  = r_state;
        n_action = r_action;
        n_status = r_status;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take_item = 1'b1;
                    n_action        = i_action;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                n_status = ST_DONE;
                case (r_action)
                    ACT_ADMIT: begin
                        if (i_stat.seat_full) begin
                            n_status = ST_FULL;
                            n_state  = S_FINISH;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    ACT_JOIN: begin
                        if (i_stat.wait_full) begin
                            n_status = ST_FULL;
                            n_state  = S_FINISH;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            o_cmd.scan_wait  = 1'b1;
                            n_state          = S_SCAN;
                        end
                    end
                    ACT_LEAVE: begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = S_SCAN;
                    end
                    default: begin
                        n_status = ST_MISSING;
                        n_state  = S_FINISH;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_FINISH;
                    case (r_action)
                        ACT_ADMIT: begin
                            if (i_stat.scan_hit) begin
                                n_status = ST_DUP;
                            end else begin
                                o_cmd.append_seat = 1'b1;
                            end
                        end
                        ACT_JOIN: begin
                            if (i_stat.scan_hit) begin
                                n_status = ST_DUP;
                            end else begin
                                o_cmd.append_wait = 1'b1;
                            end
                        end
                        ACT_LEAVE: begin
                            if (i_stat.scan_hit) begin
                                n_state = S_RDLAST;
                            end else begin
                                n_status = ST_MISSING;
                            end
                        end
                        default: n_status = ST_MISSING;
                    endcase
                end
            end
            S_RDLAST: begin
                n_state = S_MOVE;
            end
            S_MOVE: begin
                o_cmd.move_last = 1'b1;
                n_state = i_stat.wait_nonempty ? S_PROMO : S_FINISH;
            end
            S_PROMO: begin
                o_cmd.promote = 1'b1;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                if (!i_stat.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        o_cmd.status = r_status;
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_action <= ACT_ADMIT;
            r_status <= ST_DONE;
        end else begin
            r_state  <= n_state;
            r_action <= n_action;
            r_status <= n_status;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

### design/adm_dp.sv
// Datapath of the admission table: seat table and waitlist RAMs, counts,
// sequential membership scan and the result register. Depends on adm_pkg, adm_ram and the assertion header.
`include "admission_table_with_waitlist_top_assert.svh"
module adm_dp
    import adm_pkg::*;
#(
    parameter int SEAT_SLOTS = 16,
    parameter int WAIT_SLOTS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_in_beat         i_in_data,
    input  logic [CFG_W-1:0] i_seat_limit,
    input  logic [CFG_W-1:0] i_wait_limit,
    input  t_ctl_cmd         i_cmd,
    output t_dp_stat         o_stat,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output t_out_beat        o_out_data
);

    localparam int SAW  = $clog2(SEAT_SLOTS);
    localparam int WAW  = $clog2(WAIT_SLOTS);
    localparam int SCW  = $clog2(SEAT_SLOTS + 1);
    localparam int WCW  = $clog2(WAIT_SLOTS + 1);
    localparam int KW   = (SCW > WCW) ? SCW : WCW;
    localparam int MCW  = (KW > CFG_W) ? KW : CFG_W;
    localparam int TW   = WAW + 1;

    logic [ID_W-1:0] r_id;
    logic [SCW-1:0]  r_seat_cnt;
    logic [WAW-1:0]  r_wait_head;
    logic [WCW-1:0]  r_wait_fill;
    logic            r_pvalid;
    logic [ID_W-1:0] r_pid;

    // Scan state.
    logic            r_scan_wait;
    logic [KW-1:0]   r_scan_n;
    logic [KW-1:0]   r_k;
    logic [WAW-1:0]  r_wptr;
    logic            r_cmp_vld;
    logic [SAW-1:0]  r_cmp_k;
    logic            r_hit;
    logic [SAW-1:0]  r_hit_idx;

    logic            r_out_vld;
    t_out_beat       r_out_data;

    logic [ID_W-1:0] seat_rd, wait_rd, scan_rd;
    logic [SAW-1:0]  seat_rd_addr, seat_wr_addr;
    logic [WAW-1:0]  wait_rd_addr, wait_tail, wptr_inc, head_inc;
    logic [ID_W-1:0] seat_wr_data;
    logic            seat_wr_en;
    logic [SCW-1:0]  seat_last;
    logic [TW-1:0]   tail_sum;
    logic            issue, cmp_match;
    logic [MCW-1:0]  seat_cnt_x, wait_fill_x;

    assign seat_cnt_x  = MCW'(r_seat_cnt);
    assign wait_fill_x = MCW'(r_wait_fill);

    // Capacity checks against the smaller of the limit and the slot count.
    assign o_stat.seat_full = (seat_cnt_x >= MCW'(i_seat_limit))
                              || (r_seat_cnt >= SCW'(SEAT_SLOTS));
    assign o_stat.wait_full = (wait_fill_x >= MCW'(i_wait_limit))
                              || (r_wait_fill >= WCW'(WAIT_SLOTS));
    assign o_stat.wait_nonempty = (r_wait_fill != '0);
    assign o_stat.scan_hit      = r_hit;
    assign o_stat.scan_done     = r_hit || ((r_k == r_scan_n) && !r_cmp_vld);
    assign o_stat.out_busy      = r_out_vld && i_out_stall;

    // Ring index arithmetic with wrap at the slot count.
    assign tail_sum  = TW'(r_wait_head) + TW'(r_wait_fill);
    assign wait_tail = (tail_sum >= TW'(WAIT_SLOTS)) ? WAW'(tail_sum - TW'(WAIT_SLOTS))
                                                     : WAW'(tail_sum);
    assign wptr_inc  = (r_wptr == WAW'(WAIT_SLOTS - 1)) ? '0 : r_wptr + WAW'(1);
    assign head_inc  = (r_wait_head == WAW'(WAIT_SLOTS - 1)) ? '0
                                                             : r_wait_head + WAW'(1);

    // Read addresses: the scan walks one entry per cycle, otherwise the last
    // seat and the waitlist head are presented for a leave.
    assign seat_last    = r_seat_cnt - SCW'(1);
    assign seat_rd_addr = (i_cmd.scan_run && !r_scan_wait) ? r_k[SAW-1:0]
                                                           : seat_last[SAW-1:0];
    assign wait_rd_addr = (i_cmd.scan_run && r_scan_wait) ? r_wptr : r_wait_head;

    assign issue     = i_cmd.scan_run && (r_k != r_scan_n);
    assign scan_rd   = r_scan_wait ? wait_rd : seat_rd;
    assign cmp_match = r_cmp_vld && (scan_rd == r_id);

    // Seat table write port: append, fill a vacated slot, or promote.
    always_comb begin
        seat_wr_en   = 1'b0;
        seat_wr_addr = r_seat_cnt[SAW-1:0];
        seat_wr_data = r_id;
        if (i_cmd.append_seat) begin
            seat_wr_en = 1'b1;
        end else if (i_cmd.move_last) begin
            seat_wr_en   = 1'b1;
            seat_wr_addr = r_hit_idx;
            seat_wr_data = seat_rd;
        end else if (i_cmd.promote) begin
            seat_wr_en   = 1'b1;
            seat_wr_data = wait_rd;
        end
    end

    adm_ram #(
        .WIDTH (ID_W),
        .DEPTH (SEAT_SLOTS)
    ) u_seat_ram (
        .i_clk     (i_clk),
        .i_wr_en   (seat_wr_en),
        .i_wr_addr (seat_wr_addr),
        .i_wr_data (seat_wr_data),
        .i_rd_addr (seat_rd_addr),
        .o_rd_data (seat_rd)
    );

    adm_ram #(
        .WIDTH (ID_W),
        .DEPTH (WAIT_SLOTS)
    ) u_wait_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.append_wait),
        .i_wr_addr (wait_tail),
        .i_wr_data (r_id),
        .i_rd_addr (wait_rd_addr),
        .o_rd_data (wait_rd)
    );

    // Item, scan bookkeeping and payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take_item) begin
            r_id  <= i_in_data.member_id;
            r_pid <= '0;
        end
        if (i_cmd.scan_start) begin
            r_scan_wait <= i_cmd.scan_wait;
            r_scan_n    <= i_cmd.scan_wait ? KW'(r_wait_fill) : KW'(r_seat_cnt);
            r_wptr      <= r_wait_head;
        end else if (issue) begin
            r_wptr <= wptr_inc;
        end
        if (issue) begin
            r_cmp_k <= r_k[SAW-1:0];
        end
        // A promoted ID may be seated twice, so only the first match names the slot.
        if (cmp_match && !r_hit) begin
            r_hit_idx <= r_cmp_k;
        end
        if (i_cmd.promote) begin
            r_pid <= wait_rd;
        end
        if (i_cmd.load_out) begin
            r_out_data.status         <= i_cmd.status;
            r_out_data.promoted_valid <= r_pvalid;
            r_out_data.promoted_id    <= r_pid;
            r_out_data.seated_count   <= seat_cnt_x[CNT_W-1:0];
            r_out_data.waiting_count  <= wait_fill_x[CNT_W-1:0];
        end
    end

    // Control state: counts, ring head, scan flags and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seat_cnt  <= '0;
            r_wait_head <= '0;
            r_wait_fill <= '0;
            r_pvalid    <= 1'b0;
            r_k         <= '0;
            r_cmp_vld   <= 1'b0;
            r_hit       <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cmd.take_item) begin
                r_pvalid <= 1'b0;
            end
            if (i_cmd.scan_start) begin
                r_k       <= '0;
                r_cmp_vld <= 1'b0;
                r_hit     <= 1'b0;
            end else begin
                if (issue) begin
                    r_k <= r_k + KW'(1);
                end
                r_cmp_vld <= issue;
                if (cmp_match) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.append_seat) begin
                r_seat_cnt <= r_seat_cnt + SCW'(1);
            end else if (i_cmd.move_last) begin
                r_seat_cnt <= r_seat_cnt - SCW'(1);
            end else if (i_cmd.promote) begin
                r_seat_cnt <= r_seat_cnt + SCW'(1);
            end
            if (i_cmd.append_wait) begin
                r_wait_fill <= r_wait_fill + WCW'(1);
            end else if (i_cmd.promote) begin
                r_wait_fill <= r_wait_fill - WCW'(1);
                r_wait_head <= head_inc;
                r_pvalid    <= 1'b1;
            end
            if (i_cmd.load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out_data;

    // A promotion only ever drains a non-empty waitlist.
    `ADM_ASSERT_IMPL(a_promote_needs_wait, i_clk, i_rst_n, i_cmd.promote, r_wait_fill != '0)
    // A vacated slot is filled only after the scan found the ID.
    `ADM_ASSERT_IMPL(a_move_after_hit, i_clk, i_rst_n, i_cmd.move_last, r_hit)
    // A new result never overwrites one that is still stalled.
    `ADM_ASSERT_IMPL(a_no_result_overwrite, i_clk, i_rst_n, i_cmd.load_out, !o_stat.out_busy)
    // An admit grows the table by exactly one entry.
    `ADM_ASSERT_NEXT(a_admit_grows, i_clk, i_rst_n, i_cmd.append_seat, r_seat_cnt == SCW'($past(r_seat_cnt) + SCW'(1)))

endmodule

### design/admission_table_with_waitlist_top.sv
// Admission table with FIFO waitlist, top level. One item at a time: the input stalls
// from acceptance until the result is loaded. Admit and leave scan the seat table and
// join scans the waitlist, reading one RAM entry per cycle; a leave that finds its ID
// moves the last seat into the vacated slot and then promotes the waitlist head if there
// is one, and a full store rejects without a scan. The registered result beat becomes
// valid in the same cycle that the next item can be accepted. Synchronous active-low
// reset sets both limits to 10 and empties table and waitlist; no clearing pass is needed.
module admission_table_with_waitlist_top
    import adm_pkg::*;
#(
    parameter int SEAT_SLOTS = 16,
    parameter int WAIT_SLOTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_beat          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_beat         o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam logic [CFG_W-1:0] LIMIT_RESET = CFG_W'(10);

    logic [CFG_W-1:0] r_seat_limit;
    logic [CFG_W-1:0] r_wait_limit;
    logic             cfg_wr;
    t_ctl_cmd         cmd;
    t_dp_stat         stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Configuration registers; only address bit 2 selects a register, the low address bits are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seat_limit <= LIMIT_RESET;
            r_wait_limit <= LIMIT_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_SEAT_LIMIT: r_seat_limit <= pwdata[CFG_W-1:0];
                REG_WAIT_LIMIT: r_wait_limit <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback.
    always_comb begin
        case (paddr[2])
            REG_SEAT_LIMIT: prdata = DATA_W'(r_seat_limit);
            REG_WAIT_LIMIT: prdata = DATA_W'(r_wait_limit);
            default:        prdata = '0;
        endcase
    end

    adm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_data.action),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    adm_dp #(
        .SEAT_SLOTS (SEAT_SLOTS),
        .WAIT_SLOTS (WAIT_SLOTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_data    (i_in_data),
        .i_seat_limit (r_seat_limit),
        .i_wait_limit (r_wait_limit),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data)
    );

endmodule
